// ===== hdl/siu_pkg.sv =====
// siu_pkg: shared types and status codes of the segment intersection unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package siu_pkg;

    localparam int STATUS_WIDTH = 2;

    typedef logic [STATUS_WIDTH-1:0] t_status;

    localparam t_status ST_HIT       = 2'd0;
    localparam t_status ST_COLLINEAR = 2'd1;
    localparam t_status ST_PARALLEL  = 2'd2;
    localparam t_status ST_OUTSIDE   = 2'd3;

    // control that travels with each word down the pipeline
    typedef struct packed {
        logic    valid;
        logic    hit;
        t_status status;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== hdl/siu_front.sv =====
// siu_front: differences, products, cross products, classification, numerators and their magnitudes.
// Depends on siu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module siu_front #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output siu_pkg::t_ctrl                     o_ctrl,
    output logic [3*COORD_WIDTH+4:0]           o_mag_x,
    output logic [3*COORD_WIDTH+4:0]           o_mag_y,
    output logic                               o_neg_x,
    output logic                               o_neg_y,
    output logic [2*COORD_WIDTH+2:0]           o_den
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 3;
    localparam int NW = DW + W + 2;

    // stage 1: differences
    logic signed [W:0]   r_rx, r_ry, r_sx, r_sy, r_qx, r_qy;
    logic signed [W-1:0] r_px1, r_py1;
    logic                r_v1;
    // stage 2: products
    logic signed [2*W+1:0] r_rxsy, r_rysx, r_qxsy, r_qysx, r_qxry, r_qyrx;
    logic signed [W:0]     r_rx2, r_ry2;
    logic signed [W-1:0]   r_px2, r_py2;
    logic                  r_v2;
    // stage 3: cross products
    logic signed [DW-1:0] r_den3, r_tn3, r_un3;
    logic signed [W:0]    r_rx3, r_ry3;
    logic signed [W-1:0]  r_px3, r_py3;
    logic                 r_v3;
    // stage 4: classify, numerator products
    siu_pkg::t_ctrl        r_c4, n_c4;
    logic signed [DW+W-1:0] r_m1x, r_m1y;
    logic signed [DW+W:0]   r_m2x, r_m2y;
    logic [DW-1:0]         r_den4;
    logic                  r_dneg4;
    // stage 5: numerator sum
    siu_pkg::t_ctrl       r_c5;
    logic signed [NW-1:0] r_nx, r_ny;
    logic [DW-1:0]        r_den5;
    logic                 r_dneg5;
    // stage 6: magnitude
    siu_pkg::t_ctrl r_c6;
    logic [NW-1:0]  r_mx, r_my;
    logic           r_sx6, r_sy6;
    logic [DW-1:0]  r_den6;

    logic t_ok, u_ok, den_neg;

    always_comb begin
        den_neg = r_den3[DW-1];
        if (den_neg) begin
            t_ok = (r_tn3[DW-1] || (r_tn3 == '0)) && (r_tn3 >= r_den3);
            u_ok = (r_un3[DW-1] || (r_un3 == '0)) && (r_un3 >= r_den3);
        end else begin
            t_ok = !r_tn3[DW-1] && (r_tn3 <= r_den3);
            u_ok = !r_un3[DW-1] && (r_un3 <= r_den3);
        end
        n_c4.valid = r_v3;
        n_c4.hit   = 1'b0;
        if (r_den3 == '0) begin
            n_c4.status = (r_un3 == '0) ? siu_pkg::ST_COLLINEAR : siu_pkg::ST_PARALLEL;
        end else if (t_ok && u_ok) begin
            n_c4.status = siu_pkg::ST_HIT;
            n_c4.hit    = 1'b1;
        end else begin
            n_c4.status = siu_pkg::ST_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_c4 <= n_c4;
            r_c5 <= r_c4;
            r_c6 <= r_c5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx  <= (W+1)'(i_a_end_x) - (W+1)'(i_a_start_x);
        r_ry  <= (W+1)'(i_a_end_y) - (W+1)'(i_a_start_y);
        r_sx  <= (W+1)'(i_b_end_x) - (W+1)'(i_b_start_x);
        r_sy  <= (W+1)'(i_b_end_y) - (W+1)'(i_b_start_y);
        r_qx  <= (W+1)'(i_b_start_x) - (W+1)'(i_a_start_x);
        r_qy  <= (W+1)'(i_b_start_y) - (W+1)'(i_a_start_y);
        r_px1 <= i_a_start_x;
        r_py1 <= i_a_start_y;

        r_rxsy <= r_rx * r_sy;
        r_rysx <= r_ry * r_sx;
        r_qxsy <= r_qx * r_sy;
        r_qysx <= r_qy * r_sx;
        r_qxry <= r_qx * r_ry;
        r_qyrx <= r_qy * r_rx;
        r_rx2  <= r_rx;
        r_ry2  <= r_ry;
        r_px2  <= r_px1;
        r_py2  <= r_py1;

        r_den3 <= DW'(r_rxsy) - DW'(r_rysx);
        r_tn3  <= DW'(r_qxsy) - DW'(r_qysx);
        r_un3  <= DW'(r_qxry) - DW'(r_qyrx);
        r_rx3  <= r_rx2;
        r_ry3  <= r_ry2;
        r_px3  <= r_px2;
        r_py3  <= r_py2;

        // den sign is folded into the result sign later
        r_m1x   <= r_den3 * r_px3;
        r_m1y   <= r_den3 * r_py3;
        r_m2x   <= r_tn3 * r_rx3;
        r_m2y   <= r_tn3 * r_ry3;
        r_den4  <= den_neg ? DW'(-r_den3) : DW'(r_den3);
        r_dneg4 <= den_neg;

        r_nx    <= NW'(r_m1x) + NW'(r_m2x);
        r_ny    <= NW'(r_m1y) + NW'(r_m2y);
        r_den5  <= r_den4;
        r_dneg5 <= r_dneg4;

        r_mx   <= r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
        r_my   <= r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
        r_sx6  <= r_nx[NW-1] ^ r_dneg5;
        r_sy6  <= r_ny[NW-1] ^ r_dneg5;
        r_den6 <= r_den5;
    end

    assign o_ctrl  = r_c6;
    assign o_mag_x = r_mx;
    assign o_mag_y = r_my;
    assign o_neg_x = r_sx6;
    assign o_neg_y = r_sy6;
    assign o_den   = r_den6;

endmodule

`default_nettype wire

// ===== hdl/siu_div_cell.sv =====
// siu_div_cell: one restoring-division step for both coordinates.
// Depends on siu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module siu_div_cell #(
    parameter int NW    = 53,
    parameter int DW    = 35,
    parameter int QW    = 17,
    parameter int SHIFT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire siu_pkg::t_ctrl i_ctrl,
    input  wire logic [NW-1:0]  i_rem_x,
    input  wire logic [NW-1:0]  i_rem_y,
    input  wire logic [QW-1:0]  i_quot_x,
    input  wire logic [QW-1:0]  i_quot_y,
    input  wire logic           i_neg_x,
    input  wire logic           i_neg_y,
    input  wire logic [DW-1:0]  i_den,
    output siu_pkg::t_ctrl      o_ctrl,
    output logic [NW-1:0]       o_rem_x,
    output logic [NW-1:0]       o_rem_y,
    output logic [QW-1:0]       o_quot_x,
    output logic [QW-1:0]       o_quot_y,
    output logic                o_neg_x,
    output logic                o_neg_y,
    output logic [DW-1:0]       o_den
);
    logic [NW:0] dsh;
    logic        ge_x, ge_y;

    assign dsh  = (NW+1)'(i_den) << SHIFT;
    assign ge_x = (NW+1)'(i_rem_x) >= dsh;
    assign ge_y = (NW+1)'(i_rem_y) >= dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= i_ctrl;
        end
    end

    // quotient bit SHIFT arrives as zero, higher bits are already settled
    always_ff @(posedge i_clk) begin
        o_rem_x  <= ge_x ? NW'((NW+1)'(i_rem_x) - dsh) : i_rem_x;
        o_rem_y  <= ge_y ? NW'((NW+1)'(i_rem_y) - dsh) : i_rem_y;
        o_quot_x <= i_quot_x | (QW'(ge_x) << SHIFT);
        o_quot_y <= i_quot_y | (QW'(ge_y) << SHIFT);
        o_neg_x  <= i_neg_x;
        o_neg_y  <= i_neg_y;
        o_den    <= i_den;
    end

endmodule

`default_nettype wire

// ===== hdl/segment_intersection_unit.sv =====
// segment_intersection_unit: top level, front end plus a chain of division cells.
// Depends on siu_pkg, siu_front, siu_div_cell.
//
//  channel | handshake           | word
//  --------+---------------------+-------------------------------------------
//  input   | start / busy        | i_a_start_x .. i_b_end_y (8 coordinates)
//  result  | o_done (strobe)     | o_hit, o_status, o_cross_x, o_cross_y
//
// One word enters per cycle; busy stays low, the pipeline never stops.
// Pipeline: six front stages (differences, products, cross products,
// classification and numerator products, numerator sum, magnitude),
// COORD_WIDTH + 1 division cells at one quotient bit each, and the
// rounding/output register. Reset clears the control words and o_done.
// The result strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output logic                               o_done,
    output logic                               o_hit,
    output siu_pkg::t_status                   o_status,
    output logic signed [COORD_WIDTH-1:0]      o_cross_x,
    output logic signed [COORD_WIDTH-1:0]      o_cross_y
);
    localparam int W   = COORD_WIDTH;
    localparam int DW  = 2 * W + 3;     // den, tn, un
    localparam int NW  = DW + W + 2;    // numerator magnitude
    localparam int QW  = W + 1;         // quotient bits, |point| <= 2^(W-1)
    localparam int LAT = QW + 7;

    siu_pkg::t_ctrl  c_ctrl [0:QW];
    logic [NW-1:0]   c_rx   [0:QW];
    logic [NW-1:0]   c_ry   [0:QW];
    logic [QW-1:0]   c_qx   [0:QW];
    logic [QW-1:0]   c_qy   [0:QW];
    logic            c_nx   [0:QW];
    logic            c_ny   [0:QW];
    logic [DW-1:0]   c_den  [0:QW];

    assign busy = 1'b0;

    siu_front #(.COORD_WIDTH(W)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_ctrl      (c_ctrl[0]),
        .o_mag_x     (c_rx[0]),
        .o_mag_y     (c_ry[0]),
        .o_neg_x     (c_nx[0]),
        .o_neg_y     (c_ny[0]),
        .o_den       (c_den[0])
    );

    assign c_qx[0] = '0;
    assign c_qy[0] = '0;

    // cell k settles quotient bit QW-1-k, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_cell
        siu_div_cell #(.NW(NW), .DW(DW), .QW(QW), .SHIFT(QW - 1 - k)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (c_ctrl[k]),
            .i_rem_x  (c_rx[k]),
            .i_rem_y  (c_ry[k]),
            .i_quot_x (c_qx[k]),
            .i_quot_y (c_qy[k]),
            .i_neg_x  (c_nx[k]),
            .i_neg_y  (c_ny[k]),
            .i_den    (c_den[k]),
            .o_ctrl   (c_ctrl[k+1]),
            .o_rem_x  (c_rx[k+1]),
            .o_rem_y  (c_ry[k+1]),
            .o_quot_x (c_qx[k+1]),
            .o_quot_y (c_qy[k+1]),
            .o_neg_x  (c_nx[k+1]),
            .o_neg_y  (c_ny[k+1]),
            .o_den    (c_den[k+1])
        );
    end

    // round half up on magnitude (ties away from zero after the sign)
    logic [QW-1:0] q_x, q_y;
    logic [W-1:0]  n_cross_x, n_cross_y;

    always_comb begin
        q_x = c_qx[QW] + QW'({c_rx[QW], 1'b0} >= (NW+1)'(c_den[QW]));
        q_y = c_qy[QW] + QW'({c_ry[QW], 1'b0} >= (NW+1)'(c_den[QW]));
        n_cross_x = '0;
        n_cross_y = '0;
        if (c_ctrl[QW].hit) begin
            n_cross_x = c_nx[QW] ? W'(-q_x) : W'(q_x);
            n_cross_y = c_ny[QW] ? W'(-q_y) : W'(q_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= c_ctrl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit     <= c_ctrl[QW].hit;
        o_status  <= c_ctrl[QW].status;
        o_cross_x <= n_cross_x;
        o_cross_y <= n_cross_y;
    end

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_done)
        else $error("result strobe missing after pipeline latency");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_status == siu_pkg::ST_HIT))
        else $error("hit without hit status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("nonzero point on a miss");

    a_status_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == siu_pkg::ST_HIT) |-> o_hit)
        else $error("hit status without hit");

endmodule

`default_nettype wire
